### hw/rtl/segmented_least_squares_defines.svh
// Assertion helpers, included by the top-level file to check its own logic.
`ifndef SEGMENTED_LEAST_SQUARES_DEFINES_SVH
`define SEGMENTED_LEAST_SQUARES_DEFINES_SVH

// Plain property, sampled on clk, off while rst_n is low.
`define SLS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication.
`define SLS_ASSERT_IMP(lbl, ante, cons, msg) `SLS_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define SLS_ASSERT_NEXT(lbl, ante, cons, msg) `SLS_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

### hw/rtl/sls_pkg.sv
package sls_pkg;

    localparam int COORD_W        = 16;
    localparam int PEN_W          = 32;
    localparam int COST_W         = 48;
    localparam int IDX_OUT_W      = 6;
    localparam int MUL_W          = 64;
    localparam int MUL_HALF       = 32;
    localparam int TDATA_IN_W     = 32;
    localparam int TDATA_OUT_W    = 64;
    localparam int MAX_POINTS_DEF = 64;

    localparam logic [PEN_W-1:0]  PENALTY_RESET = 32'h0001_0000;
    localparam logic [COST_W-1:0] COST_MAX      = {COST_W{1'b1}};

    typedef enum logic [3:0] {
        S_LOAD,
        S_J_INIT,
        S_ISSUE,
        S_READ,
        S_START,
        S_FITW,
        S_JWR,
        S_TB_INIT,
        S_TB,
        S_EMIT_RD,
        S_EMIT_OUT
    } ctl_state_t;

    typedef enum logic [3:0] {
        F_IDLE,
        F_NSYY,
        F_SYSY,
        F_NSXX,
        F_SXSX,
        F_NSXY,
        F_SXSY,
        F_CHECK,
        F_AD,
        F_BB,
        F_ND,
        F_DIV
    } fit_state_t;

endpackage

### hw/rtl/sls_ram.sv
module sls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/sls_mul.sv
module sls_mul import sls_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [MUL_W-1:0]   a,
    input  logic [MUL_W-1:0]   b,
    output logic               done,
    output logic [2*MUL_W-1:0] prod
);

    logic [MUL_W-1:0]    a_reg, b_reg;
    logic [2*MUL_W-1:0]  acc_reg, acc_next;
    logic [MUL_W-1:0]    pp_reg;
    logic [1:0]          sel_reg;
    logic [2:0]          cnt_reg;
    logic                busy_reg, done_reg;
    logic [MUL_HALF-1:0] a_half, b_half;

    // Four 32x32 partial products, one per cycle; each is registered and added in the cycle after it is formed.
    always_comb
    begin
        a_half   = cnt_reg[1] ? a_reg[MUL_W-1:MUL_HALF] : a_reg[MUL_HALF-1:0];
        b_half   = cnt_reg[0] ? b_reg[MUL_W-1:MUL_HALF] : b_reg[MUL_HALF-1:0];
        acc_next = acc_reg + ({{MUL_W{1'b0}}, pp_reg} << {sel_reg, 5'b0});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd4)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != 3'd4)
            begin
                pp_reg  <= a_half * b_half;
                sel_reg <= 2'(cnt_reg[1]) + 2'(cnt_reg[0]);
            end
            if (cnt_reg != 3'd0)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

### hw/rtl/sls_div.sv
module sls_div #(
    parameter int NUMW = 92,
    parameter int DW   = 53
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [NUMW-1:0] num,
    input  logic [DW-1:0]   den,
    output logic            done,
    output logic [NUMW-1:0] quo
);

    localparam int CW = $clog2(NUMW);

    logic [NUMW-1:0] num_reg;
    logic [DW-1:0]   den_reg, rem_reg;
    logic [CW-1:0]   cnt_reg;
    logic            busy_reg, done_reg;
    logic [DW:0]     rem_sh, rem_sub;
    logic            q_bit;

    // Restoring division, one quotient bit per cycle; quotient bits
    // replace the numerator bits as they shift out.
    always_comb
    begin
        rem_sh  = {rem_reg, num_reg[NUMW-1]};
        rem_sub = rem_sh - {1'b0, den_reg};
        q_bit   = !rem_sub[DW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NUMW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUMW-2:0], q_bit};
            rem_reg <= q_bit ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = num_reg;

endmodule

### hw/rtl/sls_fit.sv
module sls_fit import sls_pkg::*; #(
    parameter int NW = 7
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [NW-1:0]                   n,
    input  logic signed [COORD_W+NW-1:0]    sx,
    input  logic signed [COORD_W+NW-1:0]    sy,
    input  logic signed [2*COORD_W+NW-1:0]  sxx,
    input  logic signed [2*COORD_W+NW-1:0]  syy,
    input  logic signed [2*COORD_W+NW-1:0]  sxy,
    output logic                            done,
    output logic [COST_W-1:0]               err
);

    localparam int SW   = COORD_W + NW;
    localparam int QW   = 2*COORD_W + NW;
    localparam int PW   = 2*COORD_W + 2*NW;
    localparam int NUMW = 2*PW;
    localparam int DW   = PW + NW;

    fit_state_t state_reg, state_next;

    logic [NW-1:0]         n_reg;
    logic signed [SW-1:0]  sx_reg, sy_reg;
    logic signed [QW-1:0]  sxx_reg, syy_reg, sxy_reg;
    logic signed [PW-1:0]  p1_reg, a_reg, d_reg, b_reg;
    logic [NUMW-1:0]       ad_reg;
    logic [DW-1:0]         den_reg;
    logic [COST_W-1:0]     err_reg;
    logic                  done_reg, issued_reg;

    logic                  mul_start, mul_done, div_start, div_done;
    logic [MUL_W-1:0]      mul_a, mul_b;
    logic [2*MUL_W-1:0]    mul_prod;
    logic [NUMW-1:0]       div_quo;

    logic [SW-1:0]         sx_mag, sy_mag;
    logic [QW-1:0]         sxy_mag;
    logic [PW-1:0]         b_mag;
    logic                  neg;
    logic signed [PW-1:0]  prod_s, prod_sgn;
    logic [NUMW:0]         bb_diff;
    logic                  a_pos, d_pos, mul_state;
    logic [COST_W-1:0]     q_sat;

    sls_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    sls_div #(.NUMW(NUMW), .DW(DW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (ad_reg),
        .den   (den_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        sx_mag  = sx_reg[SW-1]  ? (~sx_reg + 1'b1)  : sx_reg;
        sy_mag  = sy_reg[SW-1]  ? (~sy_reg + 1'b1)  : sy_reg;
        sxy_mag = sxy_reg[QW-1] ? (~sxy_reg + 1'b1) : sxy_reg;
        b_mag   = b_reg[PW-1]   ? (~b_reg + 1'b1)   : b_reg;
        a_pos   = !a_reg[PW-1] && (a_reg != '0);
        d_pos   = !d_reg[PW-1] && (d_reg != '0);
        prod_s  = $signed(mul_prod[PW-1:0]);
        bb_diff = {1'b0, ad_reg} - {1'b0, mul_prod[NUMW-1:0]};
        q_sat   = (div_quo[NUMW-1:COST_W] != '0) ? COST_MAX : div_quo[COST_W-1:0];
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        neg       = 1'b0;
        mul_state = 1'b1;
        unique case (state_reg)
            F_NSYY:
            begin
                mul_a = MUL_W'(n_reg);
                mul_b = MUL_W'($unsigned(syy_reg));
            end
            F_SYSY:
            begin
                mul_a = MUL_W'(sy_mag);
                mul_b = MUL_W'(sy_mag);
            end
            F_NSXX:
            begin
                mul_a = MUL_W'(n_reg);
                mul_b = MUL_W'($unsigned(sxx_reg));
            end
            F_SXSX:
            begin
                mul_a = MUL_W'(sx_mag);
                mul_b = MUL_W'(sx_mag);
            end
            F_NSXY:
            begin
                mul_a = MUL_W'(n_reg);
                mul_b = MUL_W'(sxy_mag);
                neg   = sxy_reg[QW-1];
            end
            F_SXSY:
            begin
                mul_a = MUL_W'(sx_mag);
                mul_b = MUL_W'(sy_mag);
                neg   = sx_reg[SW-1] ^ sy_reg[SW-1];
            end
            F_AD:
            begin
                mul_a = MUL_W'($unsigned(a_reg));
                mul_b = MUL_W'($unsigned(d_reg));
            end
            F_BB:
            begin
                mul_a = MUL_W'(b_mag);
                mul_b = MUL_W'(b_mag);
            end
            F_ND:
            begin
                mul_a = MUL_W'(n_reg);
                mul_b = MUL_W'($unsigned(d_reg));
            end
            default:
            begin
                mul_state = 1'b0;
            end
        endcase
        prod_sgn = neg ? -prod_s : prod_s;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:  if (start) state_next = F_NSYY;
            F_NSYY:  if (mul_done) state_next = F_SYSY;
            F_SYSY:  if (mul_done) state_next = F_NSXX;
            F_NSXX:  if (mul_done) state_next = F_SXSX;
            F_SXSX:  if (mul_done) state_next = F_NSXY;
            F_NSXY:  if (mul_done) state_next = F_SXSY;
            F_SXSY:  if (mul_done) state_next = F_CHECK;
            F_CHECK:
            begin
                if (!a_pos || n_reg == '0)
                begin
                    state_next = F_IDLE;
                end
                else if (!d_pos)
                begin
                    state_next = F_DIV;
                end
                else
                begin
                    state_next = F_AD;
                end
            end
            F_AD:    if (mul_done) state_next = F_BB;
            F_BB:    if (mul_done) state_next = bb_diff[NUMW] ? F_IDLE : F_ND;
            F_ND:    if (mul_done) state_next = F_DIV;
            F_DIV:   if (div_done) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        mul_start = mul_state && !issued_reg;
        div_start = (state_reg == F_DIV) && !issued_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            issued_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (mul_start || div_start)
            begin
                issued_reg <= 1'b1;
            end
            else if (mul_done || div_done)
            begin
                issued_reg <= 1'b0;
            end
            done_reg <= (state_reg != F_IDLE) && (state_next == F_IDLE);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    n_reg   <= n;
                    sx_reg  <= sx;
                    sy_reg  <= sy;
                    sxx_reg <= sxx;
                    syy_reg <= syy;
                    sxy_reg <= sxy;
                end
            end
            F_NSYY, F_NSXX, F_NSXY:
            begin
                if (mul_done) p1_reg <= prod_sgn;
            end
            F_SYSY:  if (mul_done) a_reg <= p1_reg - prod_sgn;
            F_SXSX:  if (mul_done) d_reg <= p1_reg - prod_sgn;
            F_SXSY:  if (mul_done) b_reg <= p1_reg - prod_sgn;
            F_CHECK:
            begin
                // Vertical run: the line is the mean of y, so the error is A / n.
                ad_reg  <= NUMW'($unsigned(a_reg));
                den_reg <= DW'(n_reg);
                err_reg <= '0;
            end
            F_AD:    if (mul_done) ad_reg <= mul_prod[NUMW-1:0];
            F_BB:
            begin
                if (mul_done)
                begin
                    ad_reg  <= bb_diff[NUMW-1:0];
                    err_reg <= '0;
                end
            end
            F_ND:    if (mul_done) den_reg <= mul_prod[DW-1:0];
            F_DIV:   if (div_done) err_reg <= q_sat;
            default:
            begin
            end
        endcase
    end

    assign done = done_reg;
    assign err  = err_reg;

endmodule

### hw/rtl/segmented_least_squares.sv
// Segmented least-squares fitter. Points stream in on s_* one item per cycle
// while the block is loading, into a point memory; the item with s_tlast set
// closes the set (further points past MAX_POINTS are dropped) and starts the
// solve. For each end point j the block walks i from j down to 0, grows the run
// sums, fits the run on a shared 32x32 multiplier (four partial products per
// 64-bit product) and a one-bit-per-cycle divider, and keeps the cheapest split
// in the best-cost and best-start memories. A solve of n points takes about
// n*(n+1)/2 runs. Segments then come out on m_* in order of position, each
// carrying the total cost, the last one with m_tlast set. Points are not
// accepted again until the final segment has been handed to the output
// register. segment_penalty is written over cfg_* at any time.
`include "segmented_least_squares_defines.svh"

module segmented_least_squares import sls_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,   // point_x[15:0], point_y[31:16]
    input  logic                   s_tlast,   // last_point
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // seg_first[5:0], seg_final[11:6], total_cost[59:12], zero[63:60]
    output logic [TDATA_OUT_W-1:0] m_tdata,
    output logic                   m_tlast,   // last_segment
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [PEN_W-1:0]       cfg_data   // segment_penalty
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int SW = COORD_W + NW;
    localparam int QW = 2*COORD_W + NW;

    ctl_state_t state_reg, state_next;

    logic [PEN_W-1:0]       penalty_reg;
    logic [NW-1:0]          point_count_reg, n_reg, k_reg, m_reg;
    logic [IW-1:0]          i_reg, j_reg, tj_reg, arg_reg;
    logic signed [SW-1:0]   sx_reg, sy_reg;
    logic signed [QW-1:0]   sxx_reg, syy_reg, sxy_reg;
    logic [COST_W-1:0]      best_reg, prev_reg, total_reg;
    logic                   m_tvalid_reg, m_tlast_reg;
    logic [TDATA_OUT_W-1:0] m_tdata_reg;

    logic                   in_acc, out_load, emit_last, fit_start, fit_done;
    logic [COST_W-1:0]      fit_err;
    logic [NW-1:0]          n_m1, emit_idx;
    logic                   pt_wr, pt_rd, bc_wr, bc_rd, bs_rd, seg_wr, seg_rd;
    logic [IW-1:0]          bc_rd_addr, bs_rd_addr;
    logic [31:0]            pt_q;
    logic [COST_W-1:0]      bc_q;
    logic [IW-1:0]          bs_q, tb_s;
    logic [2*IW-1:0]        seg_q;
    logic signed [COORD_W-1:0]   px, py;
    logic signed [2*COORD_W-1:0] pxx, pyy, pxy;
    logic [COST_W:0]        sum1, sum2;
    logic [COST_W-1:0]      sum1_sat, cand;
    logic [IW+IDX_OUT_W-1:0] first_ext, final_ext;

    sls_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_points (
        .clk     (clk),
        .wr_en   (pt_wr),
        .wr_addr (point_count_reg[IW-1:0]),
        .wr_data (s_tdata),
        .rd_en   (pt_rd),
        .rd_addr (i_reg),
        .rd_data (pt_q)
    );

    sls_ram #(.WIDTH(COST_W), .DEPTH(MAX_POINTS)) u_best_cost (
        .clk     (clk),
        .wr_en   (bc_wr),
        .wr_addr (j_reg),
        .wr_data (best_reg),
        .rd_en   (bc_rd),
        .rd_addr (bc_rd_addr),
        .rd_data (bc_q)
    );

    sls_ram #(.WIDTH(IW), .DEPTH(MAX_POINTS)) u_best_start (
        .clk     (clk),
        .wr_en   (bc_wr),
        .wr_addr (j_reg),
        .wr_data (arg_reg),
        .rd_en   (bs_rd),
        .rd_addr (bs_rd_addr),
        .rd_data (bs_q)
    );

    sls_ram #(.WIDTH(2*IW), .DEPTH(MAX_POINTS)) u_segments (
        .clk     (clk),
        .wr_en   (seg_wr),
        .wr_addr (k_reg[IW-1:0]),
        .wr_data ({tb_s, tj_reg}),
        .rd_en   (seg_rd),
        .rd_addr (emit_idx[IW-1:0]),
        .rd_data (seg_q)
    );

    sls_fit #(.NW(NW)) u_fit (
        .clk   (clk),
        .rst_n (rst_n),
        .start (fit_start),
        .n     (NW'(j_reg - i_reg) + 1'b1),
        .sx    (sx_reg),
        .sy    (sy_reg),
        .sxx   (sxx_reg),
        .syy   (syy_reg),
        .sxy   (sxy_reg),
        .done  (fit_done),
        .err   (fit_err)
    );

    always_comb
    begin
        in_acc    = s_tvalid && s_tready;
        out_load  = !m_tvalid_reg || m_tready;
        n_m1      = n_reg - 1'b1;
        emit_idx  = k_reg - m_reg - 1'b1;
        emit_last = (m_reg == k_reg - 1'b1);
        tb_s      = (bs_q > tj_reg) ? tj_reg : bs_q;
        px        = $signed(pt_q[COORD_W-1:0]);
        py        = $signed(pt_q[2*COORD_W-1:COORD_W]);
        pxx       = px * px;
        pyy       = py * py;
        pxy       = px * py;
        // Candidate cost: error + penalty + best cost before the run, saturating.
        sum1      = {1'b0, fit_err} + (COST_W+1)'(penalty_reg);
        sum1_sat  = sum1[COST_W] ? COST_MAX : sum1[COST_W-1:0];
        sum2      = {1'b0, sum1_sat} + {1'b0, prev_reg};
        cand      = sum2[COST_W] ? COST_MAX : sum2[COST_W-1:0];
        first_ext = {{IDX_OUT_W{1'b0}}, seg_q[2*IW-1:IW]};
        final_ext = {{IDX_OUT_W{1'b0}}, seg_q[IW-1:0]};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:     if (in_acc && s_tlast) state_next = S_J_INIT;
            S_J_INIT:   state_next = S_ISSUE;
            S_ISSUE:    state_next = S_READ;
            S_READ:     state_next = S_START;
            S_START:    state_next = S_FITW;
            S_FITW:
            begin
                if (fit_done)
                begin
                    state_next = (i_reg == '0) ? S_JWR : S_ISSUE;
                end
            end
            S_JWR:      state_next = (j_reg == n_m1[IW-1:0]) ? S_TB_INIT : S_J_INIT;
            S_TB_INIT:  state_next = S_TB;
            S_TB:
            begin
                if (tb_s == '0 || k_reg == NW'(MAX_POINTS - 1))
                begin
                    state_next = S_EMIT_RD;
                end
            end
            S_EMIT_RD:  state_next = S_EMIT_OUT;
            S_EMIT_OUT:
            begin
                if (out_load)
                begin
                    state_next = emit_last ? S_LOAD : S_EMIT_RD;
                end
            end
            default:    state_next = S_LOAD;
        endcase
    end

    always_comb
    begin
        s_tready   = (state_reg == S_LOAD);
        cfg_ready  = 1'b1;
        pt_wr      = 1'b0;
        pt_rd      = 1'b0;
        bc_wr      = 1'b0;
        bc_rd      = 1'b0;
        bs_rd      = 1'b0;
        seg_wr     = 1'b0;
        seg_rd     = 1'b0;
        fit_start  = 1'b0;
        bc_rd_addr = i_reg - 1'b1;
        bs_rd_addr = n_m1[IW-1:0];
        unique case (state_reg)
            S_LOAD:
            begin
                pt_wr = in_acc && (point_count_reg != NW'(MAX_POINTS));
            end
            S_ISSUE:
            begin
                pt_rd = 1'b1;
                bc_rd = (i_reg != '0);
            end
            S_START:
            begin
                fit_start = 1'b1;
            end
            S_JWR:
            begin
                bc_wr = 1'b1;
            end
            S_TB_INIT:
            begin
                bc_rd      = 1'b1;
                bc_rd_addr = n_m1[IW-1:0];
                bs_rd      = 1'b1;
            end
            S_TB:
            begin
                seg_wr     = 1'b1;
                bs_rd      = (tb_s != '0);
                bs_rd_addr = tb_s - 1'b1;
            end
            S_EMIT_RD:
            begin
                seg_rd = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_LOAD;
            penalty_reg     <= PENALTY_RESET;
            point_count_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                penalty_reg <= cfg_data;
            end
            if (state_reg == S_LOAD && in_acc)
            begin
                if (s_tlast)
                begin
                    point_count_reg <= '0;
                end
                else if (point_count_reg != NW'(MAX_POINTS))
                begin
                    point_count_reg <= point_count_reg + 1'b1;
                end
            end
            if (state_reg == S_EMIT_OUT && out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_LOAD:
            begin
                if (in_acc && s_tlast)
                begin
                    n_reg <= (point_count_reg != NW'(MAX_POINTS)) ?
                             point_count_reg + 1'b1 : point_count_reg;
                    j_reg <= '0;
                end
            end
            S_J_INIT:
            begin
                i_reg    <= j_reg;
                arg_reg  <= j_reg;
                best_reg <= COST_MAX;
                sx_reg   <= '0;
                sy_reg   <= '0;
                sxx_reg  <= '0;
                syy_reg  <= '0;
                sxy_reg  <= '0;
            end
            S_READ:
            begin
                sx_reg   <= sx_reg + SW'(px);
                sy_reg   <= sy_reg + SW'(py);
                sxx_reg  <= sxx_reg + QW'(pxx);
                syy_reg  <= syy_reg + QW'(pyy);
                sxy_reg  <= sxy_reg + QW'(pxy);
                prev_reg <= (i_reg == '0) ? '0 : bc_q;
            end
            S_FITW:
            begin
                if (fit_done)
                begin
                    // Ties go to the smaller start, which is seen later.
                    if (i_reg == j_reg || cand <= best_reg)
                    begin
                        best_reg <= cand;
                        arg_reg  <= i_reg;
                    end
                    i_reg <= i_reg - 1'b1;
                end
            end
            S_JWR:
            begin
                j_reg <= j_reg + 1'b1;
            end
            S_TB_INIT:
            begin
                tj_reg <= n_m1[IW-1:0];
                k_reg  <= '0;
            end
            S_TB:
            begin
                if (k_reg == '0)
                begin
                    total_reg <= bc_q;
                end
                k_reg  <= k_reg + 1'b1;
                tj_reg <= tb_s - 1'b1;
                m_reg  <= '0;
            end
            S_EMIT_OUT:
            begin
                if (out_load)
                begin
                    m_tdata_reg <= TDATA_OUT_W'({total_reg, final_ext[IDX_OUT_W-1:0],
                                                first_ext[IDX_OUT_W-1:0]});
                    m_tlast_reg <= emit_last;
                    m_reg       <= m_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    `SLS_ASSERT(a_count_bound, point_count_reg <= NW'(MAX_POINTS), "point count past store depth")
    `SLS_ASSERT_IMP(a_fit_done_wait, fit_done, state_reg == S_FITW, "fit finished while not waited on")
    `SLS_ASSERT_IMP(a_tb_bound, state_reg == S_TB, k_reg < NW'(MAX_POINTS), "traceback overran")
    `SLS_ASSERT_NEXT(a_emit_last, state_reg == S_EMIT_OUT && out_load && emit_last, state_reg == S_LOAD && m_tvalid && m_tlast, "final segment not flagged")

endmodule

### tb/segmented_least_squares_tb.sv
module segmented_least_squares_tb;
    import sls_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS = MAX_POINTS_DEF;
    localparam int SETTLE_CYCLES = 400;
    localparam longint CYCLE_LIMIT = 3_000_000;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] seg_first;
        logic [IDX_OUT_W-1:0] seg_final;
        logic [COST_W-1:0]    total_cost;
        logic                 last_segment;
    } segment_t;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last;
        bit                        typed;
        logic [COST_W-1:0]         typed_cost;
        logic [IDX_OUT_W-1:0]      typed_final;
    } point_row_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [TDATA_IN_W-1:0] s_tdata;   // point_x[15:0], point_y[31:16]
    logic s_tlast;                    // last_point
    logic m_tvalid;
    logic m_tready;
    // seg_first[5:0], seg_final[11:6], total_cost[59:12], zero[63:60]
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic m_tlast;                    // last_segment
    logic cfg_valid;
    logic cfg_ready;
    logic [PEN_W-1:0] cfg_data;       // segment_penalty

    segmented_least_squares u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // Predictor state
    logic [PEN_W-1:0]          penalty;
    logic signed [COORD_W-1:0] store_x [NPTS];
    logic signed [COORD_W-1:0] store_y [NPTS];
    int                        stored;
    logic [COST_W-1:0]         opt_cost [NPTS];
    int                        opt_start [NPTS];

    segment_t pending_segments[$];
    int       mismatches;
    longint   cycles;
    bit       hold_request;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [COST_W-1:0] cost_add(logic [COST_W-1:0] a, logic [COST_W-1:0] b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_W] ? COST_MAX : s[COST_W-1:0];
    endfunction

    function automatic logic [COST_W-1:0] run_residual(longint n, longint sx, longint sy,
                                                       longint sxx, longint syy, longint sxy);
        longint a, b, d;
        bit [127:0] ad, bsq, babs, q;
        a = n * syy - sy * sy;
        b = n * sxy - sx * sy;
        d = n * sxx - sx * sx;
        if (a <= 0)
            return '0;
        if (d <= 0)
            q = 128'(a) / 128'(n);
        else
        begin
            babs = (b < 0) ? 128'(-b) : 128'(b);
            ad = 128'(a) * 128'(d);
            bsq = babs * babs;
            if (ad < bsq)
                return '0;
            q = (ad - bsq) / (128'(n) * 128'(d));
        end
        return (q > 128'(COST_MAX)) ? COST_MAX : q[COST_W-1:0];
    endfunction

    // Loads one point and, on the closing point, solves and queues every segment.
    task automatic predict_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                                 logic last);
        int n, i, j, k;
        longint sx, sy, sxx, syy, sxy, xv, yv;
        logic [COST_W-1:0] best, cand, prev;
        int arg;
        int lo [$];
        int hi [$];
        segment_t seg;
        if (stored < NPTS)
        begin
            store_x[stored] = x;
            store_y[stored] = y;
            stored++;
        end
        if (!last)
            return;
        n = stored;
        for (j = 0; j < n; j++)
        begin
            sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
            best = COST_MAX;
            arg = j;
            for (i = j; i >= 0; i--)
            begin
                xv = store_x[i];
                yv = store_y[i];
                sx += xv; sy += yv; sxx += xv * xv; syy += yv * yv; sxy += xv * yv;
                prev = (i > 0) ? opt_cost[i-1] : '0;
                cand = cost_add(cost_add(run_residual(j - i + 1, sx, sy, sxx, syy, sxy),
                                         COST_W'(penalty)), prev);
                if (i == j || cand <= best)
                begin
                    best = cand;
                    arg = i;
                end
            end
            opt_cost[j] = best;
            opt_start[j] = arg;
        end
        j = n - 1;
        forever
        begin
            k = (opt_start[j] > j) ? j : opt_start[j];
            lo.push_front(k);
            hi.push_front(j);
            if (k == 0 || lo.size() >= NPTS)
                break;
            j = k - 1;
        end
        for (i = 0; i < lo.size(); i++)
        begin
            seg.seg_first = lo[i][IDX_OUT_W-1:0];
            seg.seg_final = hi[i][IDX_OUT_W-1:0];
            seg.total_cost = opt_cost[n-1];
            seg.last_segment = (i == lo.size() - 1);
            pending_segments = {pending_segments, seg};
        end
        stored = 0;
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Receiver: ready is changed at the rising edge, items are checked at the falling edge
    // just ahead of the edge that accepts them.
    always @(posedge clk)
    begin
        if (hold_request)
            m_tready <= 1'b0;
        else if ($urandom_range(0, 99) < 8)
            m_tready <= 1'b0;
        else if ($urandom_range(0, 99) < 70)
            m_tready <= 1'b1;
    end

    initial
    begin
        hold_request = 0;
        wait (stored >= 3);
        hold_request = 1;
        repeat (3000) @(posedge clk);
        hold_request = 0;
    end

    always @(negedge clk)
    begin
        segment_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_segments.size() == 0)
                report_mismatch("segment with none expected", m_tdata, 0);
            else
            begin
                want = pending_segments.pop_front();
                if (m_tdata[5:0] !== want.seg_first)
                    report_mismatch("seg_first", m_tdata[5:0], want.seg_first);
                if (m_tdata[11:6] !== want.seg_final)
                    report_mismatch("seg_final", m_tdata[11:6], want.seg_final);
                if (m_tdata[59:12] !== want.total_cost)
                    report_mismatch("total_cost", m_tdata[59:12], want.total_cost);
                if (m_tlast !== want.last_segment)
                    report_mismatch("last_segment", m_tlast, want.last_segment);
            end
        end
    end

    task automatic send_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                              logic last, bit typed, logic [COST_W-1:0] typed_cost,
                              logic [IDX_OUT_W-1:0] typed_final);
        int gap;
        segment_t seg;
        gap = ($urandom_range(0, 99) < 60) ? 0 :
              ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 4);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {y, x};
        s_tlast <= last;
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
        if (typed)
        begin
            // Directed single-segment answer typed in by hand.
            stored = 0;
            seg.seg_first = '0;
            seg.seg_final = typed_final;
            seg.total_cost = typed_cost;
            seg.last_segment = 1'b1;
            pending_segments = {pending_segments, seg};
        end
        else
            predict_point(x, y, last);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        wait (pending_segments.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_penalty(logic [PEN_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        penalty = value;
    endtask

    task automatic random_set(int size);
        int k, mode;
        logic signed [COORD_W-1:0] x, y, slope, base;
        mode = $urandom_range(0, 9);
        slope = COORD_W'(int'($urandom_range(0, 15)) - 8);
        base = COORD_W'($urandom);
        for (k = 0; k < size; k++)
        begin
            if (mode < 3)
            begin
                x = COORD_W'($urandom);
                y = COORD_W'($urandom);
            end
            else if (mode < 8)
            begin
                // Points near a few lines, with small noise.
                if ($urandom_range(0, 3) == 0)
                begin
                    slope = COORD_W'(int'($urandom_range(0, 15)) - 8);
                    base = COORD_W'(int'($urandom_range(0, 4095)) - 2048);
                end
                x = COORD_W'(k * 256 + int'($urandom_range(0, 31)));
                y = COORD_W'(int'(base) + int'(slope) * int'(x) / 8 +
                             int'($urandom_range(0, 63)));
            end
            else
            begin
                x = 16'sd1024;
                y = COORD_W'($urandom);
            end
            send_point(x, y, k == size - 1, 0, '0, '0);
        end
    endtask

    point_row_t rows [] = '{
        '{16'sd0, 16'sd0, 1'b1, 1, 48'd65536, 6'd0},
        '{-16'sd32768, -16'sd32768, 1'b0, 0, '0, '0},
        '{16'sd32767, 16'sd32767, 1'b1, 1, 48'd65536, 6'd1},
        '{16'sd0, 16'sd0, 1'b0, 0, '0, '0},
        '{16'sd256, 16'sd512, 1'b0, 0, '0, '0},
        '{16'sd512, 16'sd1024, 1'b1, 1, 48'd65536, 6'd2},
        '{16'sd5, -16'sd32768, 1'b0, 0, '0, '0},
        '{16'sd5, 16'sd32767, 1'b1, 0, '0, '0},
        '{16'sd0, 16'sd0, 1'b0, 0, '0, '0},
        '{16'sd256, 16'sd25600, 1'b0, 0, '0, '0},
        '{16'sd512, 16'sd0, 1'b0, 0, '0, '0},
        '{16'sd768, 16'sd25600, 1'b0, 0, '0, '0},
        '{16'sd1024, 16'sd0, 1'b1, 0, '0, '0},
        '{16'sd100, 16'sd100, 1'b0, 0, '0, '0},
        '{16'sd100, 16'sd100, 1'b0, 0, '0, '0},
        '{16'sd100, 16'sd100, 1'b1, 0, '0, '0},
        '{-16'sd1, 16'sd21845, 1'b0, 0, '0, '0},
        '{16'sd21845, -16'sd21846, 1'b1, 0, '0, '0}
    };

    initial
    begin
        int r, sent, size;
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        cycles = 0;
        mismatches = 0;
        stored = 0;
        penalty = PENALTY_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[r])
            send_point(rows[r].x, rows[r].y, rows[r].last, rows[r].typed,
                       rows[r].typed_cost, rows[r].typed_final);

        // Zero penalty favors many segments; ties go to the earliest start.
        write_penalty('0);
        send_point(16'sd0, 16'sd0, 1'b0, 0, '0, '0);
        send_point(16'sd0, 16'sd256, 1'b0, 0, '0, '0);
        send_point(16'sd256, 16'sd0, 1'b1, 0, '0, '0);

        sent = 0;
        while (sent < 40)
        begin
            case ((sent / 10) % 4)
                0: write_penalty('1);
                1: write_penalty($urandom);
                2: write_penalty($urandom_range(0, 1 << 20));
                default: write_penalty(PENALTY_RESET);
            endcase
            repeat (2)
            begin
                size = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
                random_set(size);
                sent += size;
            end
        end

        // Overfill the store: the two extra points are dropped, the last still closes it.
        write_penalty(32'h0000_4000);
        for (r = 0; r < NPTS + 2; r++)
            send_point(COORD_W'($urandom), COORD_W'($urandom), r == NPTS + 1, 0, '0, '0);

        drain_results();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
